// ===== design/swt_pkg.sv =====
`default_nettype none

package swt_pkg;

    // Field widths of the line scanner.
    localparam int unsigned CH_W       = 8;
    localparam int unsigned POS_W      = 17;
    localparam int unsigned WCNT_W     = 13;
    localparam int unsigned WNUM_W     = 12;
    localparam int unsigned START_W    = 16;
    localparam int unsigned CFG_W      = 17;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned OUT_USER_W = 2;

    // Largest values the configuration registers can hold.
    localparam int unsigned POS_MAX  = 131071;
    localparam int unsigned WCNT_MAX = 8191;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WORDS      = 1'b1;

    // Result queue geometry.
    localparam int unsigned RQ_DEPTH = 8;
    localparam int unsigned RQ_PTR_W = 3;
    localparam int unsigned RQ_LVL_W = 4;

    // Result kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BYTE     = 2'd0;
    localparam t_kind KIND_WORD_END = 2'd1;
    localparam t_kind KIND_LINE_END = 2'd2;

    // Quote modes.
    typedef logic [1:0] t_quote;
    localparam t_quote QUOTE_NONE   = 2'd0;
    localparam t_quote QUOTE_SINGLE = 2'd1;
    localparam t_quote QUOTE_DOUBLE = 2'd2;

    // Byte codes that steer the scanner.
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [CH_W-1:0]    out_byte;
        logic [WNUM_W-1:0]  word_number;
        logic [START_W-1:0] word_start;
        logic               tail_blank;
        logic               tail_escape;
        t_quote             tail_quote;
        logic               last;
    } t_result;

    // Results produced by one input item, handed to the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// ===== design/swt_core.sv =====
`default_nettype none

module swt_core #(
    parameter int unsigned LINE_LIMIT = 65536,
    parameter int unsigned WORD_LIMIT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [swt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swt_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [swt_pkg::CH_W-1:0]       i_ch,
    input  wire logic                           i_is_end,
    input  wire logic [swt_pkg::RQ_LVL_W-1:0]   i_level,
    output swt_pkg::t_push                      o_push
);
    import swt_pkg::*;

    // Effective limits: the configured value never exceeds the build limit.
    localparam int unsigned LINE_CAP = (LINE_LIMIT < POS_MAX) ? LINE_LIMIT : POS_MAX;
    localparam int unsigned WORD_CAP = (WORD_LIMIT < WCNT_MAX) ? WORD_LIMIT : WCNT_MAX;
    localparam int unsigned LINE_RST = (LINE_CAP < 65536) ? LINE_CAP : 65536;
    localparam int unsigned WORD_RST = (WORD_CAP < 4096) ? WORD_CAP : 4096;
    localparam logic [POS_W-1:0]  LINE_CAP_V = POS_W'(LINE_CAP);
    localparam logic [WCNT_W-1:0] WORD_CAP_V = WCNT_W'(WORD_CAP);
    localparam int unsigned LVL_X_W = RQ_LVL_W + 1;
    localparam logic [LVL_X_W-1:0] READY_MAX = LVL_X_W'(RQ_DEPTH - 2);

    logic [POS_W-1:0]   r_line_lim;
    logic [WCNT_W-1:0]  r_word_lim;

    logic               r_in_valid;
    logic [CH_W-1:0]    r_in_ch;
    logic               r_in_end;

    t_quote             r_quote, n_quote;
    logic               r_escape, n_escape;
    logic               r_active, n_active;
    logic [START_W-1:0] r_start, n_start;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [WCNT_W-1:0]  r_words, n_words;
    logic               r_space, n_space;

    t_push              push;
    logic               accept;
    logic               is_ws;
    logic               word_ok;
    logic [START_W-1:0] esc_start;
    t_result            end_res;
    t_result            byte_res;
    t_result            sum_res;

    // Room for two results per item in flight keeps the queue from overflowing.
    assign o_s_tready = ({1'b0, i_level} + (r_in_valid ? LVL_X_W'(2) : LVL_X_W'(0)))
                        <= READY_MAX;
    assign accept     = i_s_tvalid && o_s_tready;

    // Configuration registers, clipped to the build limits when written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_lim <= POS_W'(LINE_RST);
            r_word_lim <= WCNT_W'(WORD_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_LINE_BYTES: begin
                    r_line_lim <= (i_cfg_data < LINE_CAP_V) ? i_cfg_data : LINE_CAP_V;
                end
                REG_MAX_WORDS: begin
                    r_word_lim <= (i_cfg_data[WCNT_W-1:0] < WORD_CAP_V)
                                  ? i_cfg_data[WCNT_W-1:0] : WORD_CAP_V;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ch  <= i_ch;
            r_in_end <= i_is_end;
        end
    end

    // Candidate results for the byte held in the input register.
    assign is_ws     = (r_in_ch == CH_SPACE) || ((r_in_ch >= CH_TAB) && (r_in_ch <= CH_CR));
    assign word_ok   = r_words < r_word_lim;
    assign esc_start = (r_pos == '0) ? '0 : START_W'(r_pos - POS_W'(1));

    always_comb begin
        end_res             = '0;
        end_res.kind        = KIND_WORD_END;
        end_res.word_number = r_words[WNUM_W-1:0];
        end_res.word_start  = r_start;
        end_res.last        = 1'b1;

        byte_res             = '0;
        byte_res.kind        = KIND_BYTE;
        byte_res.out_byte    = r_in_ch;
        byte_res.word_number = r_words[WNUM_W-1:0];
        byte_res.last        = 1'b1;

        sum_res             = '0;
        sum_res.kind        = KIND_LINE_END;
        sum_res.tail_blank  = r_space;
        sum_res.tail_escape = r_escape;
        sum_res.tail_quote  = r_quote;
        sum_res.last        = 1'b1;
    end

    // One scanning step: next state and the results this item causes.
    always_comb begin
        n_quote  = r_quote;
        n_escape = r_escape;
        n_active = r_active;
        n_start  = r_start;
        n_pos    = r_pos;
        n_words  = r_words;
        n_space  = r_space;
        push     = '0;

        if (r_in_valid) begin
            if (r_in_end) begin
                // Line terminator: close an open word (if within the word limit), then report the summary.
                if (r_active && word_ok) begin
                    push.res0      = end_res;
                    push.res0.last = 1'b0;
                    push.res1      = sum_res;
                    push.cnt       = 2'd2;
                end else begin
                    push.res0 = sum_res;
                    push.cnt  = 2'd1;
                end
                n_quote  = QUOTE_NONE;
                n_escape = 1'b0;
                n_active = 1'b0;
                n_start  = '0;
                n_pos    = '0;
                n_words  = '0;
                n_space  = 1'b0;
            end else if (r_pos < r_line_lim) begin
                n_pos = r_pos + POS_W'(1);
                if (r_escape) begin
                    // Escaped byte is always literal.
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_start  = esc_start;
                    end
                    if (word_ok) begin
                        push.res0 = byte_res;
                        push.cnt  = 2'd1;
                    end
                    n_escape = 1'b0;
                    n_space  = 1'b0;
                end else if (r_quote == QUOTE_SINGLE) begin
                    n_space = 1'b0;
                    if (r_in_ch == CH_SQUOTE) begin
                        n_quote = QUOTE_NONE;
                    end else if (word_ok) begin
                        push.res0 = byte_res;
                        push.cnt  = 2'd1;
                    end
                end else if (r_quote == QUOTE_DOUBLE) begin
                    n_space = 1'b0;
                    if (r_in_ch == CH_DQUOTE) begin
                        n_quote = QUOTE_NONE;
                    end else if (r_in_ch == CH_BSLASH) begin
                        if (!r_active) begin
                            n_active = 1'b1;
                            n_start  = r_pos[START_W-1:0];
                        end
                        n_escape = 1'b1;
                    end else if (word_ok) begin
                        push.res0 = byte_res;
                        push.cnt  = 2'd1;
                    end
                end else if (is_ws) begin
                    // Unquoted whitespace ends the current word.
                    if (r_active) begin
                        if (word_ok) begin
                            push.res0 = end_res;
                            push.cnt  = 2'd1;
                            n_words   = r_words + WCNT_W'(1);
                        end
                        n_active = 1'b0;
                    end
                    n_space = 1'b1;
                end else begin
                    n_space = 1'b0;
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_start  = r_pos[START_W-1:0];
                    end
                    if (r_in_ch == CH_BSLASH) begin
                        n_escape = 1'b1;
                    end else if (r_in_ch == CH_SQUOTE) begin
                        n_quote = QUOTE_SINGLE;
                    end else if (r_in_ch == CH_DQUOTE) begin
                        n_quote = QUOTE_DOUBLE;
                    end else if (word_ok) begin
                        push.res0 = byte_res;
                        push.cnt  = 2'd1;
                    end
                end
            end
        end
    end

    // Line state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote  <= QUOTE_NONE;
            r_escape <= 1'b0;
            r_active <= 1'b0;
            r_start  <= '0;
            r_pos    <= '0;
            r_words  <= '0;
            r_space  <= 1'b0;
        end else begin
            r_quote  <= n_quote;
            r_escape <= n_escape;
            r_active <= n_active;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_words  <= n_words;
            r_space  <= n_space;
        end
    end

    assign o_push = push;

`ifndef ASSERT_OFF
    // Only a line terminator can produce two results.
    a_two_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (r_in_valid && r_in_end))
        else $error("two results from a non-terminator item");

    // A byte beyond the line limit leaves no trace.
    a_past_limit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_end && (r_pos >= r_line_lim))
        |=> ((r_pos == $past(r_pos)) && (r_words == $past(r_words))))
        else $error("byte past the line limit changed the state");
`endif

endmodule

`default_nettype wire

// ===== design/swt_rqueue.sv =====
`default_nettype none

module swt_rqueue (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire swt_pkg::t_push                 i_push,
    output logic [swt_pkg::RQ_LVL_W-1:0]        o_level,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output swt_pkg::t_result                    o_res
);
    import swt_pkg::*;

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wp, n_wp;
    logic [RQ_PTR_W-1:0]   r_rp, n_rp;
    logic [RQ_LVL_W-1:0]   r_count, n_count;
    logic [RQ_PTR_W-1:0]   wp_next;
    logic                  pop;

    assign wp_next    = r_wp + RQ_PTR_W'(1);
    assign o_m_tvalid = r_count != '0;
    assign pop        = o_m_tvalid && i_m_tready;
    assign o_res      = r_mem[r_rp];
    assign o_level    = r_count;

    // Up to two results are written per cycle at consecutive slots.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp_next] <= i_push.res1;
        end
    end

    // Pointer and fill level update.
    always_comb begin
        n_wp    = r_wp + RQ_PTR_W'(i_push.cnt);
        n_rp    = pop ? (r_rp + RQ_PTR_W'(1)) : r_rp;
        n_count = r_count + RQ_LVL_W'(i_push.cnt) - (pop ? RQ_LVL_W'(1) : RQ_LVL_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    // Pushes never overrun the queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0)
        |-> ((r_count + RQ_LVL_W'(i_push.cnt)) <= RQ_LVL_W'(RQ_DEPTH)))
        else $error("result queue overflow");

    // Fill level always matches the pointer distance.
    a_level_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == RQ_LVL_W'(RQ_DEPTH)) || (RQ_PTR_W'(r_wp - r_rp) == r_count[RQ_PTR_W-1:0]))
        else $error("result queue level out of step with pointers");
`endif

endmodule

`default_nettype wire

// ===== design/shell_word_tokenizer.sv =====
// Shell word tokenizer: splits a command line, one byte per beat, into words.
// Slave stream: i_s_tdata carries one line byte, i_s_tlast marks the line
// terminator beat (its data byte is ignored). Master stream: one beat per
// result; o_m_tuser is the result kind (word byte, word end, line summary),
// o_m_tlast marks the final result caused by one input beat.
// Configuration: write max_line_bytes (index 0) or max_words (index 1) through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Throughput: one input beat per cycle while o_s_tready is high. A byte produces
// at most one result; a terminator closing an open word produces two, which drain
// one per output beat through the eight-entry result queue.
// Path: a taken beat is held in the input register, and the results it causes
// are written from there into the result queue, which offers them in order.
// When the receiver stalls, the queue fills and o_s_tready drops once it could
// no longer hold two results for the beat in flight plus two for a new beat;
// nothing is lost.
// Reset clears all line state, empties the queue and sets the limits to
// 65536 bytes and 4096 words (capped by LINE_LIMIT and WORD_LIMIT).
`default_nettype none

module shell_word_tokenizer #(
    parameter int unsigned LINE_LIMIT = 65536,
    parameter int unsigned WORD_LIMIT = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [swt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [swt_pkg::CFG_W-1:0]       i_cfg_data,
    // Slave stream.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [7:0]                      i_s_tdata,   // [7:0] ch
    input  wire logic                            i_s_tlast,   // is_end
    // Master stream.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [7:0] out_byte, [19:8] word_number, [35:20] word_start,
    // [36] tail_blank, [37] tail_escape, [39:38] tail_quote
    output logic [swt_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic [swt_pkg::OUT_USER_W-1:0]       o_m_tuser,   // [1:0] kind
    output logic                                 o_m_tlast    // last
);
    import swt_pkg::*;

    t_push               push;
    t_result             res;
    logic [RQ_LVL_W-1:0] level;

    // Scanner with its input register and line state.
    swt_core #(
        .LINE_LIMIT (LINE_LIMIT),
        .WORD_LIMIT (WORD_LIMIT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_ch       (i_s_tdata),
        .i_is_end   (i_s_tlast),
        .i_level    (level),
        .o_push     (push)
    );

    // Result queue toward the master stream.
    swt_rqueue u_rqueue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_level    (level),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (res)
    );

    // Pack the result beat.
    assign o_m_tdata = {res.tail_quote, res.tail_escape, res.tail_blank,
                        res.word_start, res.word_number, res.out_byte};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

`ifndef ASSERT_OFF
    // Every result beat carries a defined kind.
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == KIND_BYTE) || (o_m_tuser == KIND_WORD_END)
                        || (o_m_tuser == KIND_LINE_END)))
        else $error("result beat with undefined kind");

    // A line summary always closes the results of its item.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_LINE_END)) |-> o_m_tlast)
        else $error("line summary not marked last");
`endif

endmodule

`default_nettype wire
